// ===== design/assert_macros.svh =====
// assertion macros shared by the rtl
// no dependencies; compiled out when SYNTHESIS is defined
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define ASSERT_IMPLIES(name, ck, rn, pre, post) \
    name: assert property (@(posedge ck) disable iff (!rn) (pre) |-> (post)) \
        else $error("implication check failed");

`define ASSERT_NEXT(name, ck, rn, pre, post) \
    name: assert property (@(posedge ck) disable iff (!rn) (pre) |=> (post)) \
        else $error("next-cycle check failed");

`else

`define ASSERT_IMPLIES(name, ck, rn, pre, post)

`define ASSERT_NEXT(name, ck, rn, pre, post)

`endif

`endif

// ===== design/cbor_pkg.sv =====
// shared constants, codes and types of the cbor item stream parser
// no dependencies
package cbor_pkg;

    localparam int COUNT_WIDTH = 32;
    localparam int CFG_W       = 32;
    localparam int CFG_INDEX_W = 1;
    localparam int ARG_W       = 64;
    localparam int ADD_W       = CFG_W + 1;
    localparam int SUM_W       = ((COUNT_WIDTH > ADD_W) ? COUNT_WIDTH : ADD_W) + 1;

    // register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_MAX_CONTAINER = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_MAX_STRING    = 1'd1;

    localparam logic [CFG_W-1:0] MAX_CONTAINER_RESET = 32'h00ff_ffff;
    localparam logic [CFG_W-1:0] MAX_STRING_RESET    = 32'hffff_ffff;

    // parser phases
    localparam logic [1:0] PH_HEADER  = 2'd0;
    localparam logic [1:0] PH_ARG     = 2'd1;
    localparam logic [1:0] PH_PAYLOAD = 2'd2;

    // result status
    localparam logic [1:0] ST_OK          = 2'd0;
    localparam logic [1:0] ST_UNSUPPORTED = 2'd1;
    localparam logic [1:0] ST_OVERRUN     = 2'd2;
    localparam logic [1:0] ST_OVERFLOW    = 2'd3;

    // item kinds
    localparam logic [2:0] K_NUMBER = 3'd0;
    localparam logic [2:0] K_BYTES  = 3'd1;
    localparam logic [2:0] K_TEXT   = 3'd2;
    localparam logic [2:0] K_ARRAY  = 3'd3;
    localparam logic [2:0] K_MAP    = 3'd4;
    localparam logic [2:0] K_BOOL   = 3'd5;
    localparam logic [2:0] K_NULL   = 3'd6;

    // major types
    localparam logic [2:0] MAJ_UINT   = 3'd0;
    localparam logic [2:0] MAJ_BYTES  = 3'd2;
    localparam logic [2:0] MAJ_TEXT   = 3'd3;
    localparam logic [2:0] MAJ_ARRAY  = 3'd4;
    localparam logic [2:0] MAJ_MAP    = 3'd5;
    localparam logic [2:0] MAJ_SIMPLE = 3'd7;

    // additional info codes
    localparam logic [4:0] INFO_DIRECT_MAX = 5'd23;
    localparam logic [4:0] INFO_LONGEST    = 5'd27;
    localparam logic [4:0] SIMPLE_FALSE    = 5'd20;
    localparam logic [4:0] SIMPLE_TRUE     = 5'd21;
    localparam logic [4:0] SIMPLE_NULL     = 5'd22;

    localparam logic [3:0] HDR_MAX = 4'd9;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_buffer;
    } byte_item_t;

    typedef struct packed {
        logic [2:0]       item_kind;
        logic [ARG_W-1:0] argument;
        logic [3:0]       header_bytes;
        logic             top_level_done;
        logic [1:0]       status;
    } result_t;

endpackage

// ===== design/cbor_in_if.sv =====
// byte channel of the cbor parser: valid, ready and one buffer byte
// no dependencies
interface cbor_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       end_of_buffer;

    modport source (output valid, output data_byte, output end_of_buffer, input ready);
    modport sink   (input valid, input data_byte, input end_of_buffer, output ready);
endinterface

// ===== design/cbor_out_if.sv =====
// item channel of the cbor parser: valid, ready and one decoded item
// no dependencies
interface cbor_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  item_kind;
    logic [63:0] argument;
    logic [3:0]  header_bytes;
    logic        top_level_done;
    logic [1:0]  status;

    modport source (output valid, output item_kind, output argument, output header_bytes,
                    output top_level_done, output status, input ready);
    modport sink   (input valid, input item_kind, input argument, input header_bytes,
                    input top_level_done, input status, output ready);
endinterface

// ===== design/cbor_item_stream_parser.sv =====
// top level of the cbor item stream parser: config registers and the three stages
// depends on cbor_pkg, cbor_in_if, cbor_out_if, cbor_in_reg, cbor_core, cbor_out_reg
//
//   port      dir     transfer carries
//   byte_ch   sink    data_byte, end_of_buffer
//   item_ch   source  item_kind, argument, header_bytes, top_level_done, status
//   cfg_*     write   cfg_index selects max_container_count or max_string_length
//
// one byte per cycle sustained while item_ch is ready; a result is registered in cbor_out_reg
// the loop through phase and pending count closes in cbor_core, combinational from its registers
// reset clears the phase, both stage valids and the pending count (to one), and reloads the limits
// a stalled item_ch holds its item and stops the core; byte_ch then takes at most one more byte,
// into the input register if it is empty, and drops ready until item_ch moves
`include "assert_macros.svh"
module cbor_item_stream_parser
    import cbor_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    cbor_in_if.sink                byte_ch,
    cbor_out_if.source             item_ch,
    input  logic                   cfg_write,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]       cfg_data
);

    logic [CFG_W-1:0] max_container_reg;
    logic [CFG_W-1:0] max_string_reg;

    logic       item_valid;
    byte_item_t item;
    logic       out_free;
    logic       step_fire;
    logic       core_res_valid;
    result_t    core_result;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_container_reg <= MAX_CONTAINER_RESET;
            max_string_reg    <= MAX_STRING_RESET;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_MAX_CONTAINER: max_container_reg <= cfg_data;
                REG_MAX_STRING:    max_string_reg    <= cfg_data;
            endcase
        end
    end

    // the core steps whenever a byte is held and a result has room
    assign step_fire = item_valid && out_free;

    cbor_in_reg u_in_reg (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_ch    (byte_ch),
        .advance    (step_fire),
        .item_valid (item_valid),
        .item       (item)
    );

    cbor_core u_core (
        .clk                 (clk),
        .rst_n               (rst_n),
        .step                (step_fire),
        .item                (item),
        .max_container_count (max_container_reg),
        .max_string_length   (max_string_reg),
        .res_valid           (core_res_valid),
        .result              (core_result)
    );

    cbor_out_reg u_out_reg (
        .clk     (clk),
        .rst_n   (rst_n),
        .item_ch (item_ch),
        .load    (step_fire && core_res_valid),
        .result  (core_result),
        .free    (out_free)
    );

    `ASSERT_NEXT(a_result_lands, clk, rst_n, step_fire && core_res_valid, item_ch.valid)
    `ASSERT_IMPLIES(a_no_stall_when_empty, clk, rst_n, !item_ch.valid, byte_ch.ready)
    `ASSERT_IMPLIES(a_error_not_top, clk, rst_n,
                    item_ch.valid && item_ch.status != ST_OK, !item_ch.top_level_done)
    `ASSERT_IMPLIES(a_ok_header_range, clk, rst_n,
                    item_ch.valid && item_ch.status == ST_OK,
                    item_ch.header_bytes != 4'd0 && item_ch.header_bytes <= HDR_MAX)

endmodule

// ===== design/cbor_in_reg.sv =====
// input register of the cbor parser: holds one byte until the core takes it
// depends on cbor_pkg and cbor_in_if
module cbor_in_reg
    import cbor_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    cbor_in_if.sink    byte_ch,
    input  logic       advance,
    output logic       item_valid,
    output byte_item_t item
);

    logic       valid_reg;
    logic       valid_next;
    byte_item_t item_reg;
    logic       load;

    // take a new byte when empty or when the held one moves on
    assign byte_ch.ready = !valid_reg || advance;
    assign load          = byte_ch.valid && byte_ch.ready;
    assign valid_next    = load || (valid_reg && !advance);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            item_reg <= '{data_byte: byte_ch.data_byte, end_of_buffer: byte_ch.end_of_buffer};
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

// ===== design/cbor_core.sv =====
// per-byte decode of the cbor parser: phase, argument collection, pending count
// depends on cbor_pkg
module cbor_core
    import cbor_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             step,
    input  byte_item_t       item,
    input  logic [CFG_W-1:0] max_container_count,
    input  logic [CFG_W-1:0] max_string_length,
    output logic             res_valid,
    output result_t          result
);

    logic [1:0]             phase_reg, phase_next;
    logic [COUNT_WIDTH-1:0] pending_reg, pending_next;
    logic [2:0]             held_reg, held_next;
    logic [ARG_W-1:0]       acc_reg, acc_next;
    logic [3:0]             hc_reg, hc_next;
    logic [3:0]             left_reg, left_next;
    logic [CFG_W-1:0]       pl_reg, pl_next;

    logic [2:0]       major;
    logic [4:0]       info;
    logic             eob;
    logic [ARG_W-1:0] acc_shift;
    logic [3:0]       hc_inc;
    logic [3:0]       left_dec;
    logic [CFG_W-1:0] pl_dec;

    logic [2:0] h_kind;
    logic       h_len;

    logic             a_fail;
    logic [1:0]       a_status;
    logic [2:0]       a_kind;
    logic [ARG_W-1:0] a_arg;
    logic [3:0]       a_hdr;
    logic             a_hd;
    logic             a_cmp;
    logic             a_enter_arg;
    logic             a_stay_arg;
    logic             a_pay_next;

    logic             is_str;
    logic             is_cont;
    logic             str_over;
    logic             cnt_over;
    logic             b_fail;
    logic [1:0]       b_status;
    logic             b_cmp;
    logic [ADD_W-1:0] b_add;
    logic             b_enter_pay;

    logic                   cmp;
    logic [COUNT_WIDTH-1:0] pending_eff;
    logic [SUM_W-1:0]       p_full;
    logic                   ovf;
    logic                   top;
    logic [1:0]             status;

    assign major     = item.data_byte[7:5];
    assign info      = item.data_byte[4:0];
    assign eob       = item.end_of_buffer;
    assign acc_shift = {acc_reg[ARG_W-9:0], item.data_byte};
    assign hc_inc    = hc_reg + 4'd1;
    assign left_dec  = left_reg - 4'd1;
    assign pl_dec    = (pl_reg == '0) ? '0 : pl_reg - CFG_W'(1);

    // major types that carry a length or value argument
    always_comb
    begin
        h_kind = K_NUMBER;
        h_len  = 1'b1;
        unique case (major)
            MAJ_UINT:  h_kind = K_NUMBER;
            MAJ_BYTES: h_kind = K_BYTES;
            MAJ_TEXT:  h_kind = K_TEXT;
            MAJ_ARRAY: h_kind = K_ARRAY;
            MAJ_MAP:   h_kind = K_MAP;
            default:   h_len  = 1'b0;
        endcase
    end

    always_comb
    begin
        a_fail      = 1'b0;
        a_status    = ST_OK;
        a_kind      = K_NUMBER;
        a_arg       = '0;
        a_hdr       = 4'd1;
        a_hd        = 1'b0;
        a_cmp       = 1'b0;
        a_enter_arg = 1'b0;
        a_stay_arg  = 1'b0;
        a_pay_next  = 1'b0;
        unique case (phase_reg)
            PH_ARG:
            begin
                a_kind = held_reg;
                a_arg  = acc_shift;
                a_hdr  = hc_inc;
                priority if (left_dec == 4'd0)
                begin
                    a_hd = 1'b1;
                end
                else if (eob)
                begin
                    a_fail   = 1'b1;
                    a_status = ST_OVERRUN;
                end
                else
                begin
                    a_stay_arg = 1'b1;
                end
            end
            PH_PAYLOAD:
            begin
                a_kind = held_reg;
                a_arg  = acc_reg;
                a_hdr  = hc_reg;
                priority if (pl_dec == '0)
                begin
                    a_cmp = 1'b1;
                end
                else if (eob)
                begin
                    a_fail   = 1'b1;
                    a_status = ST_OVERRUN;
                end
                else
                begin
                    a_pay_next = 1'b1;
                end
            end
            default:
            begin
                // header byte; the unused phase code lands here too
                priority if (major == MAJ_SIMPLE)
                begin
                    priority if (info == SIMPLE_FALSE || info == SIMPLE_TRUE)
                    begin
                        a_kind = K_BOOL;
                        a_arg  = ARG_W'(info == SIMPLE_TRUE);
                        a_cmp  = 1'b1;
                    end
                    else if (info == SIMPLE_NULL)
                    begin
                        a_kind = K_NULL;
                        a_cmp  = 1'b1;
                    end
                    else
                    begin
                        a_fail   = 1'b1;
                        a_status = ST_UNSUPPORTED;
                    end
                end
                else if (h_len)
                begin
                    a_kind = h_kind;
                    priority if (info <= INFO_DIRECT_MAX)
                    begin
                        a_arg = ARG_W'(info);
                        a_hd  = 1'b1;
                    end
                    else if (info > INFO_LONGEST)
                    begin
                        a_fail   = 1'b1;
                        a_status = ST_UNSUPPORTED;
                    end
                    else if (eob)
                    begin
                        a_fail   = 1'b1;
                        a_status = ST_OVERRUN;
                    end
                    else
                    begin
                        a_enter_arg = 1'b1;
                    end
                end
                else
                begin
                    a_fail   = 1'b1;
                    a_status = ST_UNSUPPORTED;
                end
            end
        endcase
    end

    // header complete: limit checks and string payload entry
    assign is_str   = (a_kind == K_BYTES) || (a_kind == K_TEXT);
    assign is_cont  = (a_kind == K_ARRAY) || (a_kind == K_MAP);
    assign str_over = a_arg > ARG_W'(max_string_length);
    assign cnt_over = a_arg > ARG_W'(max_container_count);

    always_comb
    begin
        b_fail      = 1'b0;
        b_status    = ST_OK;
        b_cmp       = 1'b0;
        b_add       = '0;
        b_enter_pay = 1'b0;
        if (a_hd)
        begin
            priority if (is_str)
            begin
                priority if (str_over)
                begin
                    b_fail   = 1'b1;
                    b_status = ST_OVERFLOW;
                end
                else if (a_arg == '0)
                begin
                    b_cmp = 1'b1;
                end
                else if (eob)
                begin
                    b_fail   = 1'b1;
                    b_status = ST_OVERRUN;
                end
                else
                begin
                    b_enter_pay = 1'b1;
                end
            end
            else if (is_cont)
            begin
                if (cnt_over)
                begin
                    b_fail   = 1'b1;
                    b_status = ST_OVERFLOW;
                end
                else
                begin
                    // count is known to fit the limit width here
                    b_cmp = 1'b1;
                    b_add = (a_kind == K_MAP) ? {a_arg[CFG_W-1:0], 1'b0}
                                              : {1'b0, a_arg[CFG_W-1:0]};
                end
            end
            else
            begin
                b_cmp = 1'b1;
            end
        end
    end

    // item finished: pending count update
    assign cmp         = a_cmp || b_cmp;
    assign pending_eff = (pending_reg == '0) ? COUNT_WIDTH'(1) : pending_reg;
    assign p_full      = SUM_W'(pending_eff) + SUM_W'(b_add) - SUM_W'(1);
    assign ovf         = |p_full[SUM_W-1:COUNT_WIDTH];
    assign top         = (p_full[COUNT_WIDTH-1:0] == '0);

    always_comb
    begin
        priority if (a_fail)
        begin
            status = a_status;
        end
        else if (b_fail)
        begin
            status = b_status;
        end
        else if (ovf)
        begin
            status = ST_OVERFLOW;
        end
        else if (eob && !top)
        begin
            status = ST_OVERRUN;
        end
        else
        begin
            status = ST_OK;
        end
    end

    assign res_valid = a_fail || b_fail || cmp;
    assign result    = '{item_kind:      a_kind,
                         argument:       a_arg,
                         header_bytes:   a_hdr,
                         top_level_done: cmp && !ovf && top,
                         status:         status};

    always_comb
    begin
        priority if (res_valid)
        begin
            phase_next = PH_HEADER;
        end
        else if (a_enter_arg)
        begin
            phase_next = PH_ARG;
        end
        else if (b_enter_pay)
        begin
            phase_next = PH_PAYLOAD;
        end
        else
        begin
            phase_next = phase_reg;
        end

        priority if (a_fail || b_fail)
        begin
            pending_next = COUNT_WIDTH'(1);
        end
        else if (cmp)
        begin
            pending_next = (ovf || eob || top) ? COUNT_WIDTH'(1) : p_full[COUNT_WIDTH-1:0];
        end
        else
        begin
            pending_next = pending_reg;
        end
    end

    // working registers, each written before it is read in a phase
    always_comb
    begin
        held_next = held_reg;
        acc_next  = acc_reg;
        hc_next   = hc_reg;
        left_next = left_reg;
        pl_next   = pl_reg;
        if (a_enter_arg)
        begin
            held_next = a_kind;
            hc_next   = 4'd1;
            acc_next  = '0;
            left_next = 4'd1 << info[1:0];
        end
        if (a_stay_arg)
        begin
            acc_next  = acc_shift;
            hc_next   = hc_inc;
            left_next = left_dec;
        end
        if (b_enter_pay)
        begin
            held_next = a_kind;
            hc_next   = a_hdr;
            acc_next  = a_arg;
            pl_next   = a_arg[CFG_W-1:0];
        end
        if (a_pay_next)
        begin
            pl_next = pl_dec;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_HEADER;
            pending_reg <= COUNT_WIDTH'(1);
        end
        else if (step)
        begin
            phase_reg   <= phase_next;
            pending_reg <= pending_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step)
        begin
            held_reg <= held_next;
            acc_reg  <= acc_next;
            hc_reg   <= hc_next;
            left_reg <= left_next;
            pl_reg   <= pl_next;
        end
    end

endmodule

// ===== design/cbor_out_reg.sv =====
// result register of the cbor parser: holds one item for the item channel
// depends on cbor_pkg and cbor_out_if
module cbor_out_reg
    import cbor_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    cbor_out_if.source item_ch,
    input  logic       load,
    input  result_t    result,
    output logic       free
);

    logic    valid_reg;
    logic    valid_next;
    result_t result_reg;

    // free when empty or when the held item transfers this cycle
    assign free       = !valid_reg || item_ch.ready;
    assign valid_next = load || (valid_reg && !item_ch.ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            result_reg <= result;
        end
    end

    assign item_ch.valid          = valid_reg;
    assign item_ch.item_kind      = result_reg.item_kind;
    assign item_ch.argument       = result_reg.argument;
    assign item_ch.header_bytes   = result_reg.header_bytes;
    assign item_ch.top_level_done = result_reg.top_level_done;
    assign item_ch.status         = result_reg.status;

endmodule
